FILE: design/assert_macros.svh
// Assertion helpers for the design files.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/ccrf_pkg.sv
`timescale 1ns / 1ps

package ccrf_pkg;

    // Register file geometry and field widths
    localparam int REG_COUNT = 24;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int CMD_W     = 2;
    localparam int OFF_W     = 5;
    localparam int DATA_W    = 8;

    typedef logic [DATA_W-1:0]    data_t;
    typedef logic [OFF_W-1:0]     off_t;
    typedef logic [REG_IDX_W-1:0] idx_t;

    // Command codes carried by an input item
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Calendar entries within the file
    localparam idx_t SEC_IDX  = REG_IDX_W'(2);
    localparam idx_t MIN_IDX  = REG_IDX_W'(3);
    localparam idx_t HOUR_IDX = REG_IDX_W'(4);
    localparam idx_t WDAY_IDX = REG_IDX_W'(5);
    localparam idx_t MDAY_IDX = REG_IDX_W'(6);
    localparam idx_t MON_IDX  = REG_IDX_W'(7);
    localparam idx_t YEAR_IDX = REG_IDX_W'(9);

    // Counter limits
    localparam int SEC_LIMIT  = 60;
    localparam int MIN_LIMIT  = 60;
    localparam int HOUR_LIMIT = 24;
    localparam int WEEK_DAYS  = 7;
    localparam int MONTHS     = 12;
    localparam int YEAR_SPAN  = 100;

    // Month length; year is the offset from 2000, so within 0..255 only
    // 2100 and 2200 are century years that are not leap
    function automatic data_t days_in_month(data_t month, data_t year);
        logic leap;
        data_t days;
        leap = (year[1:0] == 2'b00) && (year != 8'd100) && (year != 8'd200);
        unique case (month)
            8'd2:                        days = leap ? 8'd29 : 8'd28;
            8'd4, 8'd6, 8'd9, 8'd11:     days = 8'd30;
            default:                     days = 8'd31;
        endcase
        return days;
    endfunction

    // (w mod 7) + 1: quotient by reciprocal 73/512, one correction step
    function automatic data_t wday_next(data_t w);
        logic [14:0] prod;
        logic [5:0]  quot;
        logic [8:0]  rem;
        prod = 15'(w) * 15'd73;
        quot = prod[14:9];
        rem  = 9'(w) - (9'(quot) * 9'(WEEK_DAYS));
        if (rem >= 9'(WEEK_DAYS))
        begin
            rem = rem - 9'(WEEK_DAYS);
        end
        return 8'(rem + 9'd1);
    endfunction

    // (y + 1) mod 100 for any byte value
    function automatic data_t year_next(data_t y);
        logic [8:0] sum;
        sum = 9'(y) + 9'd1;
        if (sum >= 9'(2 * YEAR_SPAN))
        begin
            sum = sum - 9'(2 * YEAR_SPAN);
        end
        else if (sum >= 9'(YEAR_SPAN))
        begin
            sum = sum - 9'(YEAR_SPAN);
        end
        return 8'(sum);
    endfunction

endpackage

FILE: design/ccrf_req_if.sv
`timescale 1ns / 1ps

// Request channel: tick, read or write item
interface ccrf_req_if;
    logic                          valid;
    logic                          ready;
    logic [ccrf_pkg::CMD_W-1:0]    cmd;
    logic [ccrf_pkg::OFF_W-1:0]    reg_offset;
    logic [ccrf_pkg::DATA_W-1:0]   write_value;

    modport source (output valid, output cmd, output reg_offset, output write_value,
                    input ready);
    modport sink   (input valid, input cmd, input reg_offset, input write_value,
                    output ready);
endinterface

FILE: design/ccrf_rsp_if.sv
`timescale 1ns / 1ps

// Response channel: one item per read
interface ccrf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ccrf_pkg::DATA_W-1:0]   read_value;

    modport source (output valid, output read_value, input ready);
    modport sink   (input valid, input read_value, output ready);
endinterface

FILE: design/calendar_clock_register_file_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Calendar clock register file: 24 byte entries with a binary calendar.
// req carries one item per handshake: a one-second tick, a read or a write.
// rsp carries one item per read, holding the addressed byte (0 beyond the file).
// Ticks, writes and the spare command give no response item.
// An accepted item lands in an input register; from there it is executed
// against the file (tick cascade or write) and a read loads the output register.
// A read passes from the input register to the output register, which drives rsp.valid.
// Throughput: one item per cycle (single execute stage) unless a read waits on a
// stalled rsp; the tick cascade runs compare/increment steps on calendar entries.
// Items are executed strictly in order, so a read sees every earlier write/tick.
// When rsp is stalled, a waiting read holds in the input register and req.ready
// drops; ticks and writes behind a taken response still flow.
// Reset (rst_n low, asynchronous) clears every entry, the input valid flag and
// command, and the output valid flag; the calendar starts from all zero.
module calendar_clock_register_file_unit (
    input  logic          clk,
    input  logic          rst_n,
    ccrf_req_if.sink      req,
    ccrf_rsp_if.source    rsp
);
    import ccrf_pkg::*;

    // Input stage
    logic  s1_valid_reg, s1_valid_next;
    cmd_t  s1_cmd_reg,   s1_cmd_next;
    off_t  s1_off_reg,   s1_off_next;
    data_t s1_val_reg,   s1_val_next;

    // Register file
    data_t regs_reg  [REG_COUNT];
    data_t regs_next [REG_COUNT];

    // Output register
    logic  rsp_valid_reg, rsp_valid_next;
    data_t rsp_data_reg,  rsp_data_next;

    logic  out_free;
    logic  s1_fire;
    logic  in_fire;
    logic  off_ok;
    idx_t  s1_idx;
    data_t rd_data;

    // Execute strobes for the checks
    logic  rd_fire, wr_fire, sec_step;

    // Tick cascade terms
    logic [8:0] sec_sum, min_sum, hour_sum, mday_sum, mon_sum;
    data_t      month_days;

    // Handshake control
    always_comb
    begin
        out_free  = !rsp_valid_reg || rsp.ready;
        s1_fire   = s1_valid_reg && ((s1_cmd_reg != CMD_READ) || out_free);
        req.ready = !s1_valid_reg || s1_fire;
        in_fire   = req.valid && req.ready;
    end

    // Input stage load
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_cmd_next   = s1_cmd_reg;
        s1_off_next   = s1_off_reg;
        s1_val_next   = s1_val_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
            s1_cmd_next   = cmd_t'(req.cmd);
            s1_off_next   = req.reg_offset;
            s1_val_next   = req.write_value;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Addressed entry
    always_comb
    begin
        off_ok  = (32'(s1_off_reg) < 32'(REG_COUNT));
        s1_idx  = REG_IDX_W'(s1_off_reg);
        rd_data = off_ok ? regs_reg[s1_idx] : '0;
    end

    // Counter sums, one bit wider than a byte
    always_comb
    begin
        sec_sum    = 9'(regs_reg[SEC_IDX]) + 9'd1;
        min_sum    = 9'(regs_reg[MIN_IDX]) + 9'd1;
        hour_sum   = 9'(regs_reg[HOUR_IDX]) + 9'd1;
        mday_sum   = 9'(regs_reg[MDAY_IDX]) + 9'd1;
        mon_sum    = 9'(regs_reg[MON_IDX]) + 9'd1;
        month_days = days_in_month(regs_reg[MON_IDX], regs_reg[YEAR_IDX]);
    end

    // Execute: tick cascade or write
    always_comb
    begin
        regs_next = regs_reg;
        if (s1_fire)
        begin
            unique case (s1_cmd_reg)
                CMD_TICK:
                begin
                    if (sec_sum < 9'(SEC_LIMIT))
                    begin
                        regs_next[SEC_IDX] = sec_sum[7:0];
                    end
                    else
                    begin
                        regs_next[SEC_IDX] = '0;
                        if (min_sum < 9'(MIN_LIMIT))
                        begin
                            regs_next[MIN_IDX] = min_sum[7:0];
                        end
                        else
                        begin
                            regs_next[MIN_IDX] = '0;
                            if (hour_sum < 9'(HOUR_LIMIT))
                            begin
                                regs_next[HOUR_IDX] = hour_sum[7:0];
                            end
                            else
                            begin
                                regs_next[HOUR_IDX] = '0;
                                regs_next[WDAY_IDX] = wday_next(regs_reg[WDAY_IDX]);
                                if (mday_sum <= 9'(month_days))
                                begin
                                    regs_next[MDAY_IDX] = mday_sum[7:0];
                                end
                                else
                                begin
                                    regs_next[MDAY_IDX] = 8'd1;
                                    if (mon_sum <= 9'(MONTHS))
                                    begin
                                        regs_next[MON_IDX] = mon_sum[7:0];
                                    end
                                    else
                                    begin
                                        regs_next[MON_IDX]  = 8'd1;
                                        regs_next[YEAR_IDX] = year_next(regs_reg[YEAR_IDX]);
                                    end
                                end
                            end
                        end
                    end
                end
                CMD_WRITE:
                begin
                    if (off_ok)
                    begin
                        regs_next[s1_idx] = s1_val_reg;
                    end
                end
                CMD_READ, CMD_NOP:
                begin
                end
            endcase
        end
    end

    // Output register load
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        if (s1_fire && (s1_cmd_reg == CMD_READ))
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = rd_data;
        end
    end

    // Control and file registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_cmd_reg    <= CMD_NOP;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_cmd_reg    <= s1_cmd_next;
            rsp_valid_reg <= rsp_valid_next;
            regs_reg      <= regs_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_off_reg   <= s1_off_next;
        s1_val_reg   <= s1_val_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_data_reg;

    // Strobes seen by the checks
    always_comb
    begin
        rd_fire  = s1_fire && (s1_cmd_reg == CMD_READ);
        wr_fire  = s1_fire && (s1_cmd_reg == CMD_WRITE) && off_ok;
        sec_step = s1_fire && (s1_cmd_reg == CMD_TICK) && (sec_sum < 9'(SEC_LIMIT));
    end

    // Checks
    `ASSERT_NEXT(a_read_gives_rsp, rd_fire, rsp_valid_reg)
    `ASSERT_NEXT(a_write_lands, wr_fire, regs_reg[$past(s1_idx)] == $past(s1_val_reg))
    `ASSERT_NEXT(a_sec_step, sec_step, regs_reg[SEC_IDX] == $past(sec_sum[7:0]))

endmodule
